>>> design/avr_subset_decode_execute_macros.svh
// assertion helpers for the checker file
`ifndef AVR_SUBSET_DECODE_EXECUTE_MACROS_SVH
`define AVR_SUBSET_DECODE_EXECUTE_MACROS_SVH

// clocked check, off while reset is high
`define AVR_SDE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define AVR_SDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/avr_sde_pkg.sv
package avr_sde_pkg;

   localparam int PC_WIDTH   = 14;
   localparam int NEXT_PC_W  = 14;
   localparam int PC_EXT_W   = (PC_WIDTH > NEXT_PC_W) ? PC_WIDTH : NEXT_PC_W;
   localparam int REG_COUNT  = 32;
   localparam int REG_IDX_W  = 5;

   localparam logic [15:0] HALT_WORD_RESET = 16'hFFFF;

   // instruction groups, top six bits of the word
   localparam logic [5:0] GRP_ASR_JMP = 6'b100101;
   localparam logic [5:0] GRP_BR_SET  = 6'b111100;
   localparam logic [5:0] GRP_BR_CLR  = 6'b111101;
   localparam logic [5:0] GRP_ADD     = 6'b000011;
   localparam logic [5:0] GRP_ADC     = 6'b000111;
   localparam logic [5:0] GRP_AND     = 6'b001000;
   localparam logic [5:0] GRP_CP      = 6'b000101;

   // sub codes in the rr field of group 100101
   localparam logic [4:0] RR_ASR    = 5'b00101;
   localparam logic [4:0] RR_JMP_LO = 5'b01100;
   localparam logic [4:0] RR_JMP_HI = 5'b01101;

   // branch condition codes
   localparam logic [2:0] BRC_CARRY = 3'd0;
   localparam logic [2:0] BRC_ZERO  = 3'd1;
   localparam logic [2:0] BRC_SIGN  = 3'd4;

   // status bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_N = 2;
   localparam int FLAG_V = 3;
   localparam int FLAG_S = 4;
   localparam int FLAG_H = 5;

   typedef enum logic [3:0] {
      OP_UNKNOWN,
      OP_HALT,
      OP_ASR,
      OP_JMP,
      OP_BRANCH,
      OP_ADD,
      OP_ADC,
      OP_AND,
      OP_CP
   } op_type;

   typedef struct packed {
      logic [15:0] instr_word;
      logic [15:0] ext_word;
   } req_type;

   typedef struct packed {
      logic [NEXT_PC_W-1:0] next_pc;
      logic [5:0]           flags_out;
      logic                 dest_written;
      logic [4:0]           dest_index;
      logic [7:0]           dest_value;
      logic                 halt_seen;
      logic                 unknown_op;
   } rsp_type;

   // register file write back
   typedef struct packed {
      logic                 we;
      logic [REG_IDX_W-1:0] idx;
      logic [7:0]           val;
   } wb_type;

endpackage

>>> design/avr_subset_decode_execute.sv
// channel   dir  handshake            payload
// req_      in   req_valid/req_stall  req_type  (instr_word, ext_word)
// rsp_      out  rsp_valid/rsp_stall  rsp_type  (next_pc .. unknown_op)
// csr_      in   csr_we               csr_wdata (halt word)
//
// one instruction per cycle while the result is not stalled: register file
// read on accept, execute in the next cycle, with write back and the result
// register loaded at its end. after accept the item passes the stage-one
// request register and then the result register; the register file write
// port with read-after-write forwarding sets the one-per-cycle rate.
// synchronous reset clears pc, status bits and file valid bits, and sets
// the halt word to HALT_WORD_RESET; items are not accepted while reset is high.
// a stalled result holds the execute stage, which then stalls the input.
module avr_subset_decode_execute
   import avr_sde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_req_ff;
   logic                s1_go, accept;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   logic [5:0]          flags_ff, flags_in;
   logic [15:0]         halt_word_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_payload_ff, rsp_payload_in;
   logic [7:0]          ra_data, rb_data;
   wb_type              wb_exec, wb_go;
   logic                halt, unknown;
   logic [PC_EXT_W-1:0] pc_ext;

   assign s1_go        = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = reset | (s1_valid_ff & ~s1_go);
   assign accept       = req_valid & ~req_stall;
   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_go);
   assign rsp_valid_in = s1_go | (rsp_valid_ff & rsp_stall);

   avr_sde_rf u_rf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .ra_addr (req_payload.instr_word[8:4]),
      .rb_addr ({req_payload.instr_word[9], req_payload.instr_word[3:0]}),
      .wb      (wb_go),
      .ra_data (ra_data),
      .rb_data (rb_data)
   );

   avr_sde_alu u_alu (
      .instr     (s1_req_ff.instr_word),
      .ext       (s1_req_ff.ext_word),
      .halt_word (halt_word_ff),
      .a         (ra_data),
      .b         (rb_data),
      .flags_in  (flags_ff),
      .pc_in     (pc_ff),
      .flags_out (flags_in),
      .pc_out    (pc_in),
      .wb        (wb_exec),
      .halt      (halt),
      .unknown   (unknown)
   );

   always_comb begin
      wb_go    = wb_exec;
      wb_go.we = wb_exec.we & s1_go;
   end

   assign pc_ext = PC_EXT_W'(pc_in);

   always_comb begin
      rsp_payload_in.next_pc      = pc_ext[NEXT_PC_W-1:0];
      rsp_payload_in.flags_out    = flags_in;
      rsp_payload_in.dest_written = wb_exec.we;
      rsp_payload_in.dest_index   = wb_exec.idx;
      rsp_payload_in.dest_value   = wb_exec.val;
      rsp_payload_in.halt_seen    = halt;
      rsp_payload_in.unknown_op   = unknown;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         flags_ff     <= '0;
         halt_word_ff <= HALT_WORD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            pc_ff    <= pc_in;
            flags_ff <= flags_in;
         end
         if (csr_we) begin
            halt_word_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
      end
      if (s1_go) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> design/avr_sde_rf.sv
module avr_sde_rf
   import avr_sde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [REG_IDX_W-1:0] ra_addr,
   input  logic [REG_IDX_W-1:0] rb_addr,
   input  wb_type               wb,
   output logic [7:0]           ra_data,
   output logic [7:0]           rb_data
);

   logic [7:0]           regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [7:0]           ra_q_ff, rb_q_ff, fwd_val_ff;
   logic                 ra_v_ff, rb_v_ff, ra_fwd_ff, rb_fwd_ff;

   always_ff @(posedge clock) begin
      if (wb.we) begin
         regs_ff[wb.idx] <= wb.val;
      end
      if (rd_en) begin
         ra_q_ff    <= regs_ff[ra_addr];
         rb_q_ff    <= regs_ff[rb_addr];
         ra_v_ff    <= vld_ff[ra_addr];
         rb_v_ff    <= vld_ff[rb_addr];
         // a write on the same edge is not seen by the array read
         ra_fwd_ff  <= wb.we && (wb.idx == ra_addr);
         rb_fwd_ff  <= wb.we && (wb.idx == rb_addr);
         fwd_val_ff <= wb.val;
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wb.we) begin
         vld_ff[wb.idx] <= 1'b1;
      end
   end

   assign ra_data = ra_fwd_ff ? fwd_val_ff : (ra_v_ff ? ra_q_ff : 8'h00);
   assign rb_data = rb_fwd_ff ? fwd_val_ff : (rb_v_ff ? rb_q_ff : 8'h00);

endmodule

>>> design/avr_sde_alu.sv
module avr_sde_alu
   import avr_sde_pkg::*;
(
   input  logic [15:0]         instr,
   input  logic [15:0]         ext,
   input  logic [15:0]         halt_word,
   input  logic [7:0]          a,
   input  logic [7:0]          b,
   input  logic [5:0]          flags_in,
   input  logic [PC_WIDTH-1:0] pc_in,
   output logic [5:0]          flags_out,
   output logic [PC_WIDTH-1:0] pc_out,
   output wb_type              wb,
   output logic                halt,
   output logic                unknown
);

   op_type              op;
   logic [5:0]          grp;
   logic [4:0]          rr;
   logic [2:0]          cond;
   logic                take, br_bad;
   logic [7:0]          sum;
   logic [7:0]          diff, res;
   logic                cin;
   logic [PC_WIDTH-1:0] pc_inc, br_target;
   logic [5:0]          fl;

   assign grp  = instr[15:10];
   assign rr   = {instr[9], instr[3:0]};
   assign cond = instr[2:0];

   always_comb begin
      op = OP_UNKNOWN;
      if (instr == halt_word) begin
         op = OP_HALT;
      end else begin
         unique case (grp) inside
            GRP_ASR_JMP: begin
               if (rr == RR_ASR) begin
                  op = OP_ASR;
               end else if (rr == RR_JMP_LO || rr == RR_JMP_HI) begin
                  op = OP_JMP;
               end
            end
            GRP_BR_SET, GRP_BR_CLR: op = OP_BRANCH;
            GRP_ADD: op = OP_ADD;
            GRP_ADC: op = OP_ADC;
            GRP_AND: op = OP_AND;
            GRP_CP:  op = OP_CP;
            default: op = OP_UNKNOWN;
         endcase
      end
   end

   // branch condition, br_bad marks an unused condition code
   always_comb begin
      take   = 1'b0;
      br_bad = 1'b0;
      if (grp == GRP_BR_SET) begin
         case (cond)
            BRC_ZERO: take = flags_in[FLAG_Z];
            BRC_SIGN: take = flags_in[FLAG_S];
            default:  br_bad = 1'b1;
         endcase
      end else begin
         case (cond)
            BRC_ZERO:  take = ~flags_in[FLAG_Z];
            BRC_SIGN:  take = ~flags_in[FLAG_S];
            BRC_CARRY: take = ~flags_in[FLAG_C];
            default:   br_bad = 1'b1;
         endcase
      end
   end

   assign cin       = (op == OP_ADC) ? flags_in[FLAG_C] : 1'b0;
   assign sum       = a + b + {7'h00, cin};
   assign diff      = a - b;
   assign pc_inc    = pc_in + PC_WIDTH'(1);
   assign br_target = pc_inc + {{(PC_WIDTH-7){instr[9]}}, instr[9:3]};

   always_comb begin
      fl      = flags_in;
      res     = 8'h00;
      wb      = '0;
      pc_out  = pc_inc;
      halt    = 1'b0;
      unknown = 1'b0;
      unique case (op)
         OP_HALT: halt = 1'b1;
         OP_UNKNOWN: unknown = 1'b1;
         OP_ASR: begin
            res        = {a[7], a[7:1]};
            fl[FLAG_C] = a[0];
            fl[FLAG_Z] = (res == 8'h00);
            fl[FLAG_N] = res[7];
            fl[FLAG_V] = a[7] ^ a[0];
            wb         = '{we: 1'b1, idx: instr[8:4], val: res};
         end
         OP_JMP: pc_out = ext[PC_WIDTH-1:0];
         OP_BRANCH: begin
            if (br_bad) begin
               unknown = 1'b1;
            end else if (take) begin
               pc_out = br_target;
            end
         end
         OP_ADD, OP_ADC: begin
            res        = sum;
            fl[FLAG_C] = (a[7] & b[7]) | (b[7] & ~res[7]) | (~res[7] & a[7]);
            fl[FLAG_H] = (a[3] & b[3]) | (b[3] & ~res[3]) | (~res[3] & a[3]);
            fl[FLAG_Z] = (res == 8'h00);
            fl[FLAG_N] = res[7];
            fl[FLAG_V] = (a[7] & b[7] & ~res[7]) | (~a[7] & ~b[7] & res[7]);
            wb         = '{we: 1'b1, idx: instr[8:4], val: res};
         end
         OP_AND: begin
            res        = a & b;
            fl[FLAG_V] = 1'b0;
            fl[FLAG_Z] = (res == 8'h00);
            fl[FLAG_N] = res[7];
            wb         = '{we: 1'b1, idx: instr[8:4], val: res};
         end
         OP_CP: begin
            res        = diff;
            fl[FLAG_H] = (~a[3] & b[3]) | (b[3] & res[3]) | (res[3] & ~a[3]);
            fl[FLAG_V] = (a[7] & ~b[7] & ~res[7]) | (~a[7] & b[7] & res[7]);
            fl[FLAG_Z] = (res == 8'h00);
            fl[FLAG_N] = res[7];
            fl[FLAG_C] = (~a[7] & b[7]) | (b[7] & res[7]) | (res[7] & ~a[7]);
         end
         default: unknown = 1'b1;
      endcase
      // sign bit follows every instruction
      fl[FLAG_S] = fl[FLAG_N] ^ fl[FLAG_V];
   end

   assign flags_out = fl;

endmodule

>>> design/avr_sde_chk.sv
`include "avr_subset_decode_execute_macros.svh"

module avr_sde_chk
   import avr_sde_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic sign_ok, dest_idle, halt_clean;

   assign sign_ok    = rsp_payload.flags_out[FLAG_S] ==
                       (rsp_payload.flags_out[FLAG_N] ^ rsp_payload.flags_out[FLAG_V]);
   assign dest_idle  = (rsp_payload.dest_index == 5'd0) && (rsp_payload.dest_value == 8'd0);
   assign halt_clean = !rsp_payload.unknown_op && !rsp_payload.dest_written;

   `AVR_SDE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")

   `AVR_SDE_ASSERT(a_sign_flag, clock, reset, rsp_valid |-> sign_ok, "sign flag not n xor v")

   `AVR_SDE_ASSERT(a_dest_clear, clock, reset, rsp_valid && !rsp_payload.dest_written |-> dest_idle, "dest fields set without a write")

   `AVR_SDE_ASSERT(a_halt_alone, clock, reset, rsp_valid && rsp_payload.halt_seen |-> halt_clean, "halt item also executed or flagged unknown")

   `AVR_SDE_ASSERT_ALWAYS(a_rst_idle, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind avr_subset_decode_execute avr_sde_chk u_avr_sde_chk (.*);
